FILE: rtl/core/ctmf_pkg.sv
`timescale 1ns / 1ps

package ctmf_pkg;

	// block dimensions
	localparam int CHANNELS = 64;
	localparam int WINDOW   = 8;

	// field widths
	localparam int CH_W  = 6;
	localparam int SMP_W = 16;
	localparam int VAL_W = 13;

	// entries dropped at each end of the ranked window
	localparam int TRIM       = 2;
	localparam int MEAN_DIV   = WINDOW - 2 * TRIM;
	localparam int TEN_DIV    = 10;
	localparam int ROUND_BIAS = 5;

	// window store geometry
	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int AW     = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(WINDOW);

	// window sum width, also the divider operand width
	localparam int SUM_W = SMP_W + $clog2(WINDOW);

	// reciprocal constants for the constant dividers
	localparam int REC_SHIFT = 24;
	localparam int REC_W     = REC_SHIFT + 1;
	localparam logic [REC_W-1:0] MEAN_REC = REC_W'((64'd1 << REC_SHIFT) / MEAN_DIV);
	localparam logic [REC_W-1:0] TEN_REC  = REC_W'((64'd1 << REC_SHIFT) / TEN_DIV);

	typedef enum logic {
		DIV_MEAN,
		DIV_TEN
	} div_sel_t;

	typedef struct packed {
		logic     start;
		div_sel_t sel;
	} div_req_t;

	typedef struct packed {
		logic clear;
		logic en;
	} rank_ctl_t;

endpackage

FILE: rtl/core/ctmf_in_if.sv
`timescale 1ns / 1ps

interface ctmf_in_if import ctmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  channel;
	logic [SMP_W-1:0] sample;
	logic             end_of_round;
	logic             restart;

	modport source (output valid, channel, sample, end_of_round, restart, input ready);
	modport sink (input valid, channel, sample, end_of_round, restart, output ready);
endinterface

FILE: rtl/core/ctmf_out_if.sv
`timescale 1ns / 1ps

interface ctmf_out_if import ctmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  channel_out;
	logic [VAL_W-1:0] filtered_value;
	logic             from_window;

	modport source (output valid, channel_out, filtered_value, from_window, input ready);
	modport sink (input valid, channel_out, filtered_value, from_window, output ready);
endinterface

FILE: rtl/core/ctmf_window_ram.sv
`timescale 1ns / 1ps

module ctmf_window_ram import ctmf_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [SMP_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [SMP_W-1:0] rdata
);

	logic [SMP_W-1:0] mem [DEPTH];
	logic [SMP_W-1:0] rdata_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/ctmf_rank.sv
`timescale 1ns / 1ps

module ctmf_rank import ctmf_pkg::*; (
	input  logic             clk,
	input  rank_ctl_t        ctl,
	input  logic [SMP_W-1:0] data,
	output logic [SUM_W-1:0] trimmed
);

	// two lowest (lo1 <= lo2), two highest (hi1 >= hi2) and the running sum
	logic [SMP_W-1:0] lo1_q, lo2_q, hi1_q, hi2_q;
	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			lo1_q <= '1;
			lo2_q <= '1;
			hi1_q <= '0;
			hi2_q <= '0;
			sum_q <= '0;
		end else if (ctl.en) begin
			sum_q <= sum_q + SUM_W'(data);
			if (data < lo1_q) begin
				lo2_q <= lo1_q;
				lo1_q <= data;
			end else if (data < lo2_q) begin
				lo2_q <= data;
			end
			if (data > hi1_q) begin
				hi2_q <= hi1_q;
				hi1_q <= data;
			end else if (data > hi2_q) begin
				hi2_q <= data;
			end
		end
	end

	// sum of the middle entries of the ranked window
	assign trimmed = sum_q - SUM_W'(lo1_q) - SUM_W'(lo2_q) - SUM_W'(hi1_q) - SUM_W'(hi2_q);

endmodule

FILE: rtl/core/ctmf_const_div.sv
`timescale 1ns / 1ps

module ctmf_const_div import ctmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [SUM_W-1:0] x,
	output logic             done,
	output logic [SUM_W-1:0] q
);

	localparam int PW = SUM_W + REC_W;

	logic             v_s1, v_s2, done_q;
	logic [SUM_W-1:0] x_s1, x_s2, q_q;
	div_sel_t         sel_s1, sel_s2;
	logic [PW-1:0]    prod_s2;
	logic [REC_W-1:0] rec;
	logic [SUM_W-1:0] q_est, d_x, qd, rem;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= req.start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_s1   <= x;
			sel_s1 <= req.sel;
		end
	end

	assign rec = (sel_s1 == DIV_MEAN) ? MEAN_REC : TEN_REC;

	// reciprocal multiply
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PW'(x_s1) * PW'(rec);
			x_s2    <= x_s1;
			sel_s2  <= sel_s1;
		end
	end

	// estimate is exact or one low, one compare fixes it
	assign q_est = SUM_W'(prod_s2 >> REC_SHIFT);
	assign d_x   = (sel_s2 == DIV_MEAN) ? SUM_W'(MEAN_DIV) : SUM_W'(TEN_DIV);
	assign qd    = q_est * d_x;
	assign rem   = x_s2 - qd;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			q_q <= (rem >= d_x) ? q_est + SUM_W'(1) : q_est;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

FILE: rtl/core/cell_voltage_trimmed_mean_filter_top.sv
`timescale 1ns / 1ps

// Cell voltage trimmed mean filter.
// samples: one transaction per raw cell sample with its channel, an end-of-round
// mark and a restart mark. results: one transaction per sample with the channel,
// the filtered value (tenths, rounded) and a flag telling a window mean from a
// raw value.
// The per-channel windows live in one single-port-write, registered-read memory
// of CHANNELS x WINDOW words. A sample is written on acceptance; when the
// window is full its WINDOW entries are read back one per cycle and ranked on
// the fly, then one shared constant divider (reciprocal multiply) forms the
// mean and then the rounded tenth; a raw value takes one divider pass only.
// A window mean goes through the window read-back and the two divider passes.
// One item is in work at a time; samples.ready is high only while idle, so a
// new sample is taken only once the last result is in the output register.
// After reset the memory is swept to zero, one word per cycle, over all
// CHANNELS x WINDOW words before the first sample is taken.
// The result sits in an output register; a stalled receiver holds it and the
// next sample is still taken, its result waiting until the register frees.

module cell_voltage_trimmed_mean_filter_top import ctmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ctmf_in_if.sink     samples,
	ctmf_out_if.source  results
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_MEAN,
		ST_MEAN_WAIT,
		ST_ROUND_WAIT,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [SLOT_W-1:0] slot_q, rd_cnt_q;
	logic              full_q;
	logic [AW-1:0]     base_q;
	logic [CH_W-1:0]   ch_q;
	logic              win_q;
	logic              rd_valid_s1;
	logic              out_valid_q, out_win_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [VAL_W-1:0]  out_val_q;

	logic              accept, ch_ok, full_eff, win_eff, out_free, clearing;
	logic [SLOT_W-1:0] slot_eff;
	logic [SLOT_W:0]   slot_inc;
	logic [AW-1:0]     wr_addr, base_d;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [SMP_W-1:0]  ram_wdata, ram_rdata;

	rank_ctl_t         rank_ctl;
	logic [SUM_W-1:0]  trimmed;

	div_req_t          div_req;
	logic [SUM_W-1:0]  div_x, div_q;
	logic              div_done;

	// input transaction and item decode
	assign samples.ready = (state_q == ST_IDLE);
	assign accept    = samples.valid && samples.ready;
	assign ch_ok     = ((CH_W + 1)'(samples.channel) < (CH_W + 1)'(CHANNELS));
	assign slot_eff  = samples.restart ? '0 : slot_q;
	assign full_eff  = samples.restart ? 1'b0 : full_q;
	assign win_eff   = ch_ok && full_eff;
	assign slot_inc  = (SLOT_W + 1)'(slot_eff) + (SLOT_W + 1)'(1);
	assign base_d    = AW'(32'(samples.channel) * WINDOW);
	assign wr_addr   = AW'(32'(samples.channel) * WINDOW + 32'(slot_eff));
	assign out_free  = !out_valid_q || results.ready;
	assign clearing  = (state_q == ST_CLEAR);

	// memory ports; the write lands before any read of the same word is issued
	assign ram_we    = clearing || (accept && ch_ok);
	assign ram_waddr = clearing ? clr_cnt_q : wr_addr;
	assign ram_wdata = clearing ? '0 : samples.sample;
	assign ram_re    = (state_q == ST_READ);
	assign ram_raddr = base_q + AW'(rd_cnt_q);

	ctmf_window_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ranking fed straight from the read port
	assign rank_ctl.clear = accept;
	assign rank_ctl.en    = rd_valid_s1;

	ctmf_rank u_rank (
		.clk     (clk),
		.ctl     (rank_ctl),
		.data    (ram_rdata),
		.trimmed (trimmed)
	);

	// divider requests: raw tenth, window mean, tenth of the mean
	always_comb begin
		div_req.start = (accept && !win_eff) || (state_q == ST_MEAN) ||
			(state_q == ST_MEAN_WAIT && div_done);
		div_req.sel   = (state_q == ST_MEAN) ? DIV_MEAN : DIV_TEN;
		if (accept) begin
			div_x = SUM_W'(samples.sample) + SUM_W'(ROUND_BIAS);
		end else if (state_q == ST_MEAN) begin
			div_x = trimmed;
		end else begin
			div_x = div_q + SUM_W'(ROUND_BIAS);
		end
	end

	ctmf_const_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.x      (div_x),
		.done   (div_done),
		.q      (div_q)
	);

	// sequencer, slot and full flag, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			rd_cnt_q    <= '0;
			base_q      <= '0;
			ch_q        <= '0;
			win_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_win_q   <= 1'b0;
			out_ch_q    <= '0;
			out_val_q   <= '0;
		end else begin
			rd_valid_s1 <= ram_re;
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ch_q     <= samples.channel;
						win_q    <= win_eff;
						base_q   <= base_d;
						rd_cnt_q <= '0;
						// slot and flag move after this item's result is decided
						if (samples.end_of_round) begin
							if (slot_inc == (SLOT_W + 1)'(WINDOW)) begin
								slot_q <= '0;
								full_q <= 1'b1;
							end else begin
								slot_q <= SLOT_W'(slot_inc);
								full_q <= full_eff;
							end
						end else begin
							slot_q <= slot_eff;
							full_q <= full_eff;
						end
						state_q <= win_eff ? ST_READ : ST_ROUND_WAIT;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + SLOT_W'(1);
					if (rd_cnt_q == SLOT_W'(WINDOW - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (div_done) begin
						state_q <= ST_ROUND_WAIT;
					end
				end
				ST_ROUND_WAIT, ST_FINISH: begin
					if (state_q == ST_FINISH || div_done) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_ch_q    <= ch_q;
							out_val_q   <= VAL_W'(div_q);
							out_win_q   <= win_q;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.channel_out    = out_ch_q;
	assign results.filtered_value = out_val_q;
	assign results.from_window    = out_win_q;

endmodule

FILE: rtl/core/ctmf_checker.sv
`timescale 1ns / 1ps

module ctmf_checker import ctmf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CH_W-1:0]  channel_out,
	input logic [VAL_W-1:0] filtered_value,
	input logic             from_window
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(channel_out) &&
			$stable(filtered_value) && $stable(from_window)))
		else $error("stalled result changed or dropped");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample taken while busy");

	// a tenth of a 16-bit value stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (filtered_value <= VAL_W'(6554)))
		else $error("filtered value out of range");

	// a result is posted as the sequencer returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while busy");

endmodule

bind cell_voltage_trimmed_mean_filter_top ctmf_checker u_ctmf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.channel_out    (results.channel_out),
	.filtered_value (results.filtered_value),
	.from_window    (results.from_window)
);

FILE: tb/sv/cell_voltage_trimmed_mean_filter_top_tb.sv
`timescale 1ns / 1ps

module cell_voltage_trimmed_mean_filter_top_tb;
	import ctmf_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0]  channel;
		logic [VAL_W-1:0] value;
		logic             from_window;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ctmf_in_if  samples_if ();
	ctmf_out_if results_if ();

	cell_voltage_trimmed_mean_filter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	// shadow copy of the filter state
	logic [SMP_W-1:0] window_copy [CHANNELS][WINDOW];
	int               slot_copy;
	logic             full_copy;

	cell_result_t pending_filtered [$];

	// per-channel nominal cell level for the sweeps
	int nominal_level [CHANNELS];

	int src_idle_pct;
	int sink_stall_pct;
	int hold_off_left;
	int mismatches;
	int samples_sent;
	int results_checked;
	int window_results;
	int restarts_sent;

	always #1 clk = ~clk;

	// expected result for one accepted sample, advancing the shadow state
	function automatic cell_result_t filter_next_sample(input logic [CH_W-1:0] ch,
		input logic [SMP_W-1:0] smp, input logic eor, input logic rst);
		cell_result_t     r;
		logic [SMP_W-1:0] ranked [WINDOW];
		logic [SMP_W-1:0] t;
		int               sum;
		int               i;
		int               j;
		if (rst) begin
			slot_copy = 0;
			full_copy = 1'b0;
		end
		r.channel     = ch;
		r.from_window = 1'b0;
		r.value       = VAL_W'((int'(smp) + ROUND_BIAS) / TEN_DIV);
		if (int'(ch) < CHANNELS) begin
			window_copy[ch][slot_copy] = smp;
			if (full_copy) begin
				for (i = 0; i < WINDOW; i++)
					ranked[i] = window_copy[ch][i];
				// bubble the window into ascending order
				for (i = 0; i < WINDOW - 1; i++)
					for (j = 0; j < WINDOW - 1 - i; j++)
						if (ranked[j] > ranked[j+1]) begin
							t           = ranked[j];
							ranked[j]   = ranked[j+1];
							ranked[j+1] = t;
						end
				sum = 0;
				for (i = TRIM; i < WINDOW - TRIM; i++)
					sum += int'(ranked[i]);
				r.value       = VAL_W'((sum / MEAN_DIV + ROUND_BIAS) / TEN_DIV);
				r.from_window = 1'b1;
			end
		end
		// slot and full flag move only after the result is formed
		if (eor) begin
			if (slot_copy == WINDOW - 1) begin
				slot_copy = 0;
				full_copy = 1'b1;
			end else begin
				slot_copy++;
			end
		end
		return r;
	endfunction

	// sample close to the channel's level, now and then an outlier
	function automatic logic [SMP_W-1:0] sample_near(input logic [CH_W-1:0] ch);
		int v;
		if ($urandom_range(9) == 0)
			return SMP_W'($urandom_range(65535));
		v = nominal_level[ch] + int'($urandom_range(400)) - 200;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return SMP_W'(v);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 100)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// one sample transaction, entered and left at a falling edge
	task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp,
		input logic eor, input logic rst);
		while ($urandom_range(99) < src_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid        <= 1'b1;
		samples_if.channel      <= ch;
		samples_if.sample       <= smp;
		samples_if.end_of_round <= eor;
		samples_if.restart      <= rst;
		do
			@(posedge clk);
		while (!samples_if.ready);
		pending_filtered.push_back(filter_next_sample(ch, smp, eor, rst));
		samples_sent++;
		if (rst)
			restarts_sent++;
		@(negedge clk);
	endtask

	// sender pauses until every expected result has come
	task automatic wait_results_drained();
		samples_if.valid <= 1'b0;
		while (pending_filtered.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// raw path before the window is full: field extremes and rounding edges
	task automatic test_raw_rounding();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_sample(CH_W'(0), SMP_W'(0), 1'b0, 1'b1);
		send_sample(CH_W'(63), SMP_W'(65535), 1'b0, 1'b0);
		send_sample(CH_W'(1), SMP_W'(4), 1'b0, 1'b0);
		send_sample(CH_W'(1), SMP_W'(5), 1'b0, 1'b0);
		send_sample(CH_W'(2), SMP_W'(14), 1'b0, 1'b0);
		send_sample(CH_W'(2), SMP_W'(15), 1'b0, 1'b0);
		send_sample(CH_W'(42), 16'hAAAA, 1'b0, 1'b0);
		send_sample(CH_W'(21), 16'h5555, 1'b0, 1'b0);
	endtask

	// fill the window, wrap the slot, then restart back to raw
	task automatic test_window_fill();
		int i;
		// the wrapping round still sees the old full flag
		for (i = 0; i < WINDOW; i++)
			send_sample(CH_W'(63), SMP_W'((i % 2 == 1) ? 65535 - i * 7 : i * 9001),
				1'b1, 1'b0);
		send_sample(CH_W'(63), SMP_W'(65535), 1'b0, 1'b0);
		// unwritten entries of channel zero still rank as zero
		send_sample(CH_W'(0), SMP_W'(12345), 1'b0, 1'b0);
		send_sample(CH_W'(62), SMP_W'(1000), 1'b1, 1'b1);
		send_sample(CH_W'(63), SMP_W'(7), 1'b0, 1'b0);
	endtask

	// well-formed sweeps over a small channel group, with some noise
	task automatic test_random_sweeps(input int n_items, input int idle, input int stall);
		int   sent;
		int   first;
		int   width;
		int   i;
		logic rst;
		src_idle_pct   = idle;
		sink_stall_pct = stall;
		sent  = 0;
		first = $urandom_range(CHANNELS - 1);
		width = $urandom_range(5, 1);
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_sample(CH_W'($urandom_range(63)), SMP_W'($urandom_range(65535)),
					1'($urandom_range(3) == 0), 1'($urandom_range(19) == 0));
				sent++;
			end else begin
				if ($urandom_range(29) == 0) begin
					first = $urandom_range(CHANNELS - 1);
					width = $urandom_range(5, 1);
				end
				rst = 1'($urandom_range(59) == 0);
				for (i = 0; i < width; i++) begin
					send_sample(CH_W'(first + i), sample_near(CH_W'(first + i)),
						1'(i == width - 1), rst && (i == 0));
					sent++;
				end
			end
		end
	endtask

	// receiver holds off while the sender keeps pushing, so input stalls
	task automatic test_output_stall();
		int i;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		hold_off_left = 200;
		@(negedge clk);
		for (i = 0; i < 30; i++)
			send_sample(CH_W'(i % 3), sample_near(CH_W'(i % 3)), 1'(i % 3 == 2), 1'b0);
	endtask

	// receiver ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			results_if.ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			results_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		cell_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_filtered.size() == 0) begin
				report_mismatch("result with nothing expected, channel",
					int'(results_if.channel_out), -1);
			end else begin
				want = pending_filtered.pop_front();
				results_checked++;
				if (want.from_window)
					window_results++;
				if (results_if.channel_out !== want.channel)
					report_mismatch("channel_out", int'(results_if.channel_out),
						int'(want.channel));
				if (results_if.filtered_value !== want.value)
					report_mismatch("filtered_value", int'(results_if.filtered_value),
						int'(want.value));
				if (results_if.from_window !== want.from_window)
					report_mismatch("from_window", int'(results_if.from_window),
						int'(want.from_window));
			end
		end
	end

	// run limit
	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int c;
		int i;
		arst_n                  = 1'b0;
		samples_if.valid        = 1'b0;
		samples_if.channel      = '0;
		samples_if.sample       = '0;
		samples_if.end_of_round = 1'b0;
		samples_if.restart      = 1'b0;
		results_if.ready        = 1'b0;
		src_idle_pct            = 0;
		sink_stall_pct          = 0;
		hold_off_left           = 0;
		mismatches              = 0;
		samples_sent            = 0;
		results_checked         = 0;
		window_results          = 0;
		restarts_sent           = 0;
		slot_copy               = 0;
		full_copy               = 1'b0;
		for (c = 0; c < CHANNELS; c++) begin
			nominal_level[c] = $urandom_range(65535);
			for (i = 0; i < WINDOW; i++)
				window_copy[c][i] = '0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_raw_rounding();
		test_window_fill();
		wait_results_drained();
		test_random_sweeps(280, 0, 0);
		wait_results_drained();
		test_random_sweeps(280, 65, 0);
		wait_results_drained();
		test_random_sweeps(280, 0, 65);
		wait_results_drained();
		test_output_stall();
		wait_results_drained();
		test_random_sweeps(280, 35, 35);
		wait_results_drained();

		// let any stray result show up
		repeat (40) @(posedge clk);
		if (pending_filtered.size() != 0)
			report_mismatch("results still outstanding", 0, pending_filtered.size());

		$display("run covered %0d samples (%0d restarts), %0d results checked, %0d from full windows",
			samples_sent, restarts_sent, results_checked, window_results);
		$display("idle and stall phases plus a 200 cycle output hold-off, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ctmf_pkg.sv
rtl/core/ctmf_in_if.sv
rtl/core/ctmf_out_if.sv
rtl/core/ctmf_window_ram.sv
rtl/core/ctmf_rank.sv
rtl/core/ctmf_const_div.sv
rtl/core/cell_voltage_trimmed_mean_filter_top.sv
rtl/core/ctmf_checker.sv
tb/sv/cell_voltage_trimmed_mean_filter_top_tb.sv
